/* rtl/mep_pkg.sv */
// ----------------------------------------------------------------------------
// MUS event stream parser package
// Shared types and constants for the byte-serial MUS music parser.
// ----------------------------------------------------------------------------
package mep_pkg;

    localparam int unsigned POS_W = 18;

    typedef enum logic [3:0] {
        PH_SIG,
        PH_HDR,
        PH_INSTR,
        PH_CHECK,
        PH_EVENT,
        PH_PAY1,
        PH_PAY2,
        PH_DELAY,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        KIND_HEADER = 3'd0,
        KIND_INSTR  = 3'd1,
        KIND_EVENT  = 3'd2,
        KIND_DELAY  = 3'd3,
        KIND_END    = 3'd4,
        KIND_ERROR  = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_SIGNATURE  = 2'd0,
        ERR_PADDING    = 2'd1,
        ERR_UNKNOWN    = 2'd2,
        ERR_UNEXPECTED = 2'd3
    } t_error;

    localparam logic [2:0] EV_PLAY       = 3'd1;
    localparam logic [2:0] EV_CONTROLLER = 3'd4;
    localparam logic [2:0] EV_MEASURE    = 3'd5;
    localparam logic [2:0] EV_END        = 3'd6;
    localparam logic [2:0] EV_UNKNOWN    = 3'd7;

    localparam logic [7:0] MASK_TYPE    = 8'h07;
    localparam logic [7:0] MASK_CHANNEL = 8'h0F;
    localparam logic [7:0] MASK_FLAG    = 8'h80;
    localparam logic [7:0] MASK_LOW7    = ~8'h80;

    localparam logic [2:0] LAST_HDR_WORD = 3'd5;
    localparam logic [2:0] SONG_OFS_WORD = 3'd1;
    localparam logic [2:0] INSTR_CNT_WORD = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] word_index;
        logic [15:0] word_value;
        logic [2:0]  event_type;
        logic [3:0]  channel;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic        has_second;
        logic        ends_tick;
        logic [31:0] delay;
        logic [1:0]  error_code;
    } t_result;

    typedef struct packed {
        logic halted;
    } t_status;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h4D;
            2'd1: b = 8'h55;
            2'd2: b = 8'h53;
            default: b = 8'h1A;
        endcase
        return b;
    endfunction

endpackage

/* rtl/mep_decode.sv */
// ----------------------------------------------------------------------------
// MUS parser decode stage
// Holds the parse state and turns one byte per transfer into at most one
// result, all in combinational logic.
// ----------------------------------------------------------------------------
module mep_decode import mep_pkg::*; #(
    parameter int unsigned DELAY_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_result,
    output t_status o_status
);

    t_phase                 r_phase, n_phase;
    logic [POS_W-1:0]       r_position, n_position;
    logic [7:0]             r_low_byte, n_low_byte;
    logic [15:0]            r_song_offset, n_song_offset;
    logic [15:0]            r_instr_total, n_instr_total;
    logic [15:0]            r_instr_left, n_instr_left;
    logic [2:0]             r_cur_type, n_cur_type;
    logic [3:0]             r_cur_channel, n_cur_channel;
    logic                   r_cur_last, n_cur_last;
    logic [7:0]             r_payload_first, n_payload_first;
    logic                   r_volume_pending, n_volume_pending;
    logic [DELAY_WIDTH-1:0] r_delay_acc, n_delay_acc;

    logic [POS_W-1:0]        pos_inc;
    logic [POS_W-1:0]        hdr_idx;
    logic [15:0]             word;
    t_phase                  eff_phase;
    logic                    res_valid;
    t_result                 res;

    assign pos_inc   = r_position + POS_W'(1);
    assign hdr_idx   = (pos_inc - POS_W'(5)) >> 1;
    assign word      = {i_item.data_byte, r_low_byte};

    always_comb begin
        n_phase          = r_phase;
        n_position       = r_position;
        n_low_byte       = r_low_byte;
        n_song_offset    = r_song_offset;
        n_instr_total    = r_instr_total;
        n_instr_left     = r_instr_left;
        n_cur_type       = r_cur_type;
        n_cur_channel    = r_cur_channel;
        n_cur_last       = r_cur_last;
        n_payload_first  = r_payload_first;
        n_volume_pending = r_volume_pending;
        n_delay_acc      = r_delay_acc;
        res_valid        = 1'b0;
        res              = '0;
        eff_phase        = (r_phase == PH_CHECK) ? PH_EVENT : r_phase;

        if (r_phase == PH_DONE) begin
            res_valid = 1'b0;
        end else if (r_phase == PH_CHECK && r_position != POS_W'(r_song_offset)) begin
            res_valid      = 1'b1;
            res.result_kind = KIND_ERROR;
            res.error_code = ERR_PADDING;
            n_phase        = PH_DONE;
        end else if (i_item.stream_end) begin
            res_valid      = 1'b1;
            res.result_kind = KIND_ERROR;
            res.error_code = ERR_UNEXPECTED;
            n_phase        = PH_DONE;
        end else begin
            n_phase = eff_phase;
            case (eff_phase)
                PH_SIG: begin
                    if (i_item.data_byte != sig_byte(r_position[1:0])) begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_SIGNATURE;
                        n_phase         = PH_DONE;
                    end else begin
                        n_position = pos_inc;
                        if (pos_inc >= POS_W'(4)) begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_HDR, PH_INSTR: begin
                    n_position = pos_inc;
                    if (!r_position[0]) begin
                        n_low_byte = i_item.data_byte;
                    end else begin
                        res_valid      = 1'b1;
                        res.word_value = word;
                        if (eff_phase == PH_HDR) begin
                            res.result_kind = KIND_HEADER;
                            res.word_index  = 16'(hdr_idx);
                            if (hdr_idx == POS_W'(SONG_OFS_WORD)) begin
                                n_song_offset = word;
                            end
                            if (hdr_idx == POS_W'(INSTR_CNT_WORD)) begin
                                n_instr_total = word;
                                n_instr_left  = word;
                            end
                            if (hdr_idx == POS_W'(LAST_HDR_WORD)) begin
                                n_phase = (r_instr_left == 16'd0) ? PH_CHECK : PH_INSTR;
                            end
                        end else begin
                            res.result_kind = KIND_INSTR;
                            res.word_index  = r_instr_total - r_instr_left;
                            n_instr_left    = r_instr_left - 16'd1;
                            if (n_instr_left == 16'd0) begin
                                n_phase = PH_CHECK;
                            end
                        end
                    end
                end
                PH_EVENT: begin
                    n_cur_type       = 3'((i_item.data_byte >> 4) & MASK_TYPE);
                    n_cur_channel    = 4'(i_item.data_byte & MASK_CHANNEL);
                    n_cur_last       = i_item.data_byte[7];
                    n_payload_first  = 8'd0;
                    n_volume_pending = 1'b0;
                    if (n_cur_type == EV_UNKNOWN) begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_UNKNOWN;
                        n_phase         = PH_DONE;
                    end else if (n_cur_type == EV_END) begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_END;
                        res.event_type  = EV_END;
                        res.channel     = n_cur_channel;
                        res.ends_tick   = n_cur_last;
                        n_phase         = PH_DONE;
                    end else if (n_cur_type == EV_MEASURE) begin
                        res_valid = 1'b1;
                    end else begin
                        n_phase = PH_PAY1;
                    end
                end
                PH_PAY1: begin
                    if (r_cur_type == EV_PLAY) begin
                        n_payload_first = i_item.data_byte & MASK_LOW7;
                        if ((i_item.data_byte & MASK_FLAG) != 8'd0) begin
                            n_volume_pending = 1'b1;
                            n_phase          = PH_PAY2;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end else begin
                        n_payload_first = i_item.data_byte;
                        if (r_cur_type == EV_CONTROLLER) begin
                            n_phase = PH_PAY2;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end
                end
                PH_PAY2: begin
                    n_volume_pending = 1'b0;
                    res_valid        = 1'b1;
                    res.second_value = i_item.data_byte;
                    res.has_second   = 1'b1;
                end
                PH_DELAY: begin
                    n_delay_acc = (r_delay_acc << 7)
                                + DELAY_WIDTH'(i_item.data_byte & MASK_LOW7);
                    if ((i_item.data_byte & MASK_FLAG) == 8'd0) begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_DELAY;
                        res.delay       = 32'(n_delay_acc);
                        n_phase         = PH_EVENT;
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            // Event results share one format; the result kind is left at zero
            // above only for these paths.
            if (res_valid && (eff_phase == PH_PAY1 || eff_phase == PH_PAY2 ||
                              (eff_phase == PH_EVENT && n_cur_type == EV_MEASURE))) begin
                res.result_kind = KIND_EVENT;
                res.event_type  = n_cur_type;
                res.channel     = n_cur_channel;
                res.first_value = n_payload_first;
                res.ends_tick   = n_cur_last;
                if (n_cur_last) begin
                    n_delay_acc = '0;
                    n_phase     = PH_DELAY;
                end else begin
                    n_phase = PH_EVENT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_SIG;
            r_position       <= '0;
            r_low_byte       <= '0;
            r_song_offset    <= '0;
            r_instr_total    <= '0;
            r_instr_left     <= '0;
            r_cur_type       <= '0;
            r_cur_channel    <= '0;
            r_cur_last       <= 1'b0;
            r_payload_first  <= '0;
            r_volume_pending <= 1'b0;
            r_delay_acc      <= '0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_position       <= n_position;
            r_low_byte       <= n_low_byte;
            r_song_offset    <= n_song_offset;
            r_instr_total    <= n_instr_total;
            r_instr_left     <= n_instr_left;
            r_cur_type       <= n_cur_type;
            r_cur_channel    <= n_cur_channel;
            r_cur_last       <= n_cur_last;
            r_payload_first  <= n_payload_first;
            r_volume_pending <= n_volume_pending;
            r_delay_acc      <= n_delay_acc;
        end
    end

    assign o_res_valid     = res_valid;
    assign o_result        = res;
    assign o_status.halted = (r_phase == PH_DONE);

endmodule

/* rtl/mep_out_reg.sv */
// ----------------------------------------------------------------------------
// MUS parser result register
// One-entry output register that can be reloaded in the cycle it is drained.
// ----------------------------------------------------------------------------
module mep_out_reg import mep_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_space,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

/* rtl/mus_event_stream_parser.sv */
// ----------------------------------------------------------------------------
// MUS event stream parser
// Parses a MUS music file one byte per transfer and reports header words,
// instrument words, events, tick delays, the end event and errors.
//
// The input channel (i_valid, o_ready, i_item) carries one file byte or an
// end-of-stream mark per transfer. The output channel (o_valid, i_ready,
// o_result) carries the results; each input byte gives zero or one result.
// A byte is decoded in the cycle it is accepted and its result appears in the
// output register on the next cycle. The block takes one byte every cycle as
// long as the output register is empty or is drained in the same cycle; the
// single output register sets that figure. When the receiver stalls with a
// result waiting, o_ready drops until the result is taken. After an end event
// or an error the parser halts and accepts bytes without producing results
// until reset. Reset is synchronous and returns the parser to the signature
// check with no result pending.
// ----------------------------------------------------------------------------
module mus_event_stream_parser import mep_pkg::*; #(
    parameter int unsigned DELAY_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    step;
    logic    res_valid;
    t_result res;
    t_status status;
    logic    space;

    assign o_ready = space;
    assign step    = i_valid && space;

    mep_decode #(
        .DELAY_WIDTH(DELAY_WIDTH)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (i_item),
        .o_res_valid(res_valid),
        .o_result   (res),
        .o_status   (status)
    );

    mep_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_result(res),
        .o_space (space),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(o_result)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.halted && !o_valid |=> !o_valid)
        else $error("Result produced after the parser halted.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.result_kind == KIND_ERROR ||
                    o_result.result_kind == KIND_END) |-> status.halted)
        else $error("End or error result without the parser halting.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Input stalled while the result register is empty.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("Stalled result changed before its transfer.");

endmodule
